@@ design/spnh_pkg.sv @@
// ----------------------------------------------------------------------------
// spnh_pkg
// Shared types and constants of the shortest path next hop engine.
// ----------------------------------------------------------------------------
package spnh_pkg;

    localparam int MAX_NODES = 16;
    localparam int NODE_BITS = 4;
    localparam int CNT_BITS  = 5;
    localparam int COST_BITS = 16;
    localparam int DIST_BITS = 24;
    localparam int LINK_BITS = 2 * NODE_BITS;

    localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic REG_SOURCE = 1'b0;
    localparam logic REG_COUNT  = 1'b1;

    typedef struct packed {
        logic                 kind;
        logic [NODE_BITS-1:0] from_node;
        logic [NODE_BITS-1:0] to_node;
        logic [COST_BITS-1:0] link_cost;
        logic                 link_up;
    } item_t;

    typedef struct packed {
        logic [NODE_BITS-1:0] next_hop;
        logic [DIST_BITS-1:0] path_cost;
        logic                 reachable;
    } result_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic init;
        logic scan_clear;
        logic scan_step;
        logic pick;
        logic rd_issue;
        logic relax;
        logic trace_start;
        logic trace_step;
        logic finish_zero;
        logic finish_self;
        logic finish_path;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic bad_query;
        logic self_query;
        logic scan_last;
        logic found;
        logic relax_last;
        logic rounds_last;
        logic dst_reached;
        logic trace_done;
    } status_t;

endpackage

@@ design/shortest_path_next_hop.sv @@
// ----------------------------------------------------------------------------
// shortest_path_next_hop
// Dijkstra next hop engine over a directed link table of up to 16 nodes.
// ----------------------------------------------------------------------------
// A word is accepted on a clock edge where start is high and busy is low.
// A link write takes effect at once, gives no result and leaves busy low, so
// writes may follow each other in every cycle while no query holds busy. A
// query raises busy and gives exactly one result word, shown for one cycle
// with done high; the receiver cannot stall it, so it must take the word in
// that cycle. A query whose source or destination lies outside the node
// count, or whose destination is the source itself, finishes from the check
// state without a search. A search runs up to n rounds of a minimum scan of
// all n nodes and a relaxation over n neighbors, then a path trace of at most
// n hops, with n the effective node count. The sequencer scans one node per
// cycle for the minimum and relaxes each neighbor in a read and an update
// state, since the link cost memory has a single registered read port.
// Configuration is written through the APB port: source_node at address 0,
// node_count at address 4. Write it only while the block is idle.
// ----------------------------------------------------------------------------
module shortest_path_next_hop (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  spnh_pkg::item_t   item,
    output logic              done,
    output spnh_pkg::result_t result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [spnh_pkg::NODE_BITS-1:0] source_node_reg;
    logic [spnh_pkg::CNT_BITS-1:0]  node_count_reg;
    logic                           accept;
    logic                           cfg_wr;
    spnh_pkg::cmd_t                 cmd;
    spnh_pkg::status_t              stat;

    assign pready = 1'b1;
    assign accept = start && !busy;
    assign cfg_wr = psel && penable && pwrite;

    // Register writes; the index is the word address bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_node_reg <= '0;
            node_count_reg  <= spnh_pkg::CNT_BITS'(spnh_pkg::MAX_NODES);
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == spnh_pkg::REG_SOURCE)
            begin
                source_node_reg <= pwdata[spnh_pkg::NODE_BITS-1:0];
            end
            else
            begin
                node_count_reg <= pwdata[spnh_pkg::CNT_BITS-1:0];
            end
        end
    end

    always_comb
    begin
        if (paddr[2] == spnh_pkg::REG_COUNT)
        begin
            prdata = {{(32-spnh_pkg::CNT_BITS){1'b0}}, node_count_reg};
        end
        else
        begin
            prdata = {{(32-spnh_pkg::NODE_BITS){1'b0}}, source_node_reg};
        end
    end

    spnh_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .query_accept (accept && (item.kind == spnh_pkg::KIND_QUERY)),
        .stat         (stat),
        .cmd          (cmd),
        .busy         (busy)
    );

    spnh_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .item        (item),
        .source_node (source_node_reg),
        .node_count  (node_count_reg),
        .cmd         (cmd),
        .stat        (stat),
        .done        (done),
        .result      (result)
    );

endmodule

@@ design/spnh_ctrl.sv @@
// ----------------------------------------------------------------------------
// spnh_ctrl
// Sequencer of the search: checks, minimum scan, relaxation and path trace.
// ----------------------------------------------------------------------------
module spnh_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             query_accept,
    input  spnh_pkg::status_t stat,
    output spnh_pkg::cmd_t   cmd,
    output logic             busy
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_PICK  = 3'd3;
    localparam logic [2:0] ST_RD    = 3'd4;
    localparam logic [2:0] ST_UPD   = 3'd5;
    localparam logic [2:0] ST_TRACE = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (query_accept)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (stat.bad_query)
                begin
                    cmd.finish_zero = 1'b1;
                    state_next      = ST_IDLE;
                end
                else if (stat.self_query)
                begin
                    cmd.finish_self = 1'b1;
                    state_next      = ST_IDLE;
                end
                else
                begin
                    cmd.init       = 1'b1;
                    cmd.scan_clear = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = ST_PICK;
                end
            end
            ST_PICK:
            begin
                if (stat.found)
                begin
                    cmd.pick   = 1'b1;
                    state_next = ST_RD;
                end
                else
                begin
                    cmd.trace_start = 1'b1;
                    state_next      = ST_TRACE;
                end
            end
            ST_RD:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_UPD;
            end
            ST_UPD:
            begin
                cmd.relax = 1'b1;
                if (!stat.relax_last)
                begin
                    state_next = ST_RD;
                end
                else if (stat.rounds_last)
                begin
                    cmd.trace_start = 1'b1;
                    state_next      = ST_TRACE;
                end
                else
                begin
                    cmd.scan_clear = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_TRACE:
            begin
                if (!stat.dst_reached)
                begin
                    cmd.finish_zero = 1'b1;
                    state_next      = ST_IDLE;
                end
                else if (stat.trace_done)
                begin
                    cmd.finish_path = 1'b1;
                    state_next      = ST_IDLE;
                end
                else
                begin
                    cmd.trace_step = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

@@ design/spnh_dp.sv @@
// ----------------------------------------------------------------------------
// spnh_dp
// Link tables, per-node search state, counters and the result register.
// ----------------------------------------------------------------------------
module spnh_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 accept,
    input  spnh_pkg::item_t                      item,
    input  logic [spnh_pkg::NODE_BITS-1:0]       source_node,
    input  logic [spnh_pkg::CNT_BITS-1:0]        node_count,
    input  spnh_pkg::cmd_t                       cmd,
    output spnh_pkg::status_t                    stat,
    output logic                                 done,
    output spnh_pkg::result_t                    result
);

    localparam int NB = spnh_pkg::NODE_BITS;
    localparam int CB = spnh_pkg::CNT_BITS;
    localparam int DB = spnh_pkg::DIST_BITS;
    localparam int KB = spnh_pkg::COST_BITS;
    localparam int NN = spnh_pkg::MAX_NODES;
    localparam int LB = spnh_pkg::LINK_BITS;

    // Link cost memory; an entry is used only where its present bit is set.
    logic [KB-1:0] cost_mem [NN*NN];
    logic [KB-1:0] cost_q;
    logic [NN*NN-1:0] pres_reg;
    logic          pres_q;

    logic [DB-1:0] dist_reg [NN];
    logic [NB-1:0] pred_reg [NN];
    logic [NN-1:0] vis_reg;
    logic [NN-1:0] que_reg;
    logic [NN-1:0] rch_reg;

    logic [NB-1:0] src_reg;
    logic [NB-1:0] dst_reg;
    logic [CB-1:0] n_reg;
    logic [NB-1:0] i_reg;
    logic [CB-1:0] round_reg;
    logic          found_reg;
    logic [NB-1:0] best_idx_reg;
    logic [DB-1:0] best_dist_reg;
    logic [NB-1:0] u_reg;
    logic [DB-1:0] du_reg;
    logic [NB-1:0] hop_reg;
    logic [CB-1:0] steps_reg;
    logic          done_reg;
    spnh_pkg::result_t result_reg;

    logic [CB-1:0] n_eff;
    logic          wr_en;
    logic [LB-1:0] wr_addr;
    logic          cand;
    logic [DB:0]   sum_w;
    logic [DB-1:0] sum_sat;
    logic          upd;
    logic          last_i;

    always_comb
    begin
        if (node_count == '0)
        begin
            n_eff = CB'(1);
        end
        else if (node_count > CB'(NN))
        begin
            n_eff = CB'(NN);
        end
        else
        begin
            n_eff = node_count;
        end
    end

    assign wr_en   = accept && (item.kind == spnh_pkg::KIND_WRITE);
    assign wr_addr = {item.from_node, item.to_node};

    assign cand = que_reg[i_reg] && !vis_reg[i_reg]
                  && (!found_reg || (dist_reg[i_reg] < best_dist_reg));
    assign sum_w   = {1'b0, du_reg} + {{(DB+1-KB){1'b0}}, cost_q};
    assign sum_sat = sum_w[DB] ? spnh_pkg::DIST_MAX : sum_w[DB-1:0];
    assign upd     = pres_q && !vis_reg[i_reg]
                     && (!rch_reg[i_reg] || (sum_sat < dist_reg[i_reg]));
    assign last_i  = ({1'b0, i_reg} == (n_reg - CB'(1)));

    assign stat.bad_query   = ({1'b0, src_reg} >= n_reg) || ({1'b0, dst_reg} >= n_reg);
    assign stat.self_query  = (src_reg == dst_reg);
    assign stat.scan_last   = last_i;
    assign stat.found       = found_reg;
    assign stat.relax_last  = last_i;
    assign stat.rounds_last = ((round_reg + CB'(1)) == n_reg);
    assign stat.dst_reached = rch_reg[i_reg];
    assign stat.trace_done  = (steps_reg == n_reg) || (pred_reg[hop_reg] == src_reg);

    always_ff @(posedge clk)
    begin
        if (wr_en && item.link_up)
        begin
            cost_mem[wr_addr] <= item.link_cost;
        end
        if (cmd.rd_issue)
        begin
            cost_q <= cost_mem[{u_reg, i_reg}];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pres_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                pres_reg[wr_addr] <= item.link_up;
            end
            done_reg <= cmd.finish_zero || cmd.finish_self || cmd.finish_path;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (item.kind == spnh_pkg::KIND_QUERY))
        begin
            src_reg <= source_node;
            dst_reg <= item.to_node;
            n_reg   <= n_eff;
        end
        if (cmd.init)
        begin
            for (int k = 0; k < NN; k++)
            begin
                dist_reg[k] <= (NB'(k) == src_reg) ? '0 : spnh_pkg::DIST_MAX;
                pred_reg[k] <= (NB'(k) == src_reg) ? src_reg : '0;
            end
            vis_reg           <= '0;
            que_reg           <= NN'(1) << src_reg;
            rch_reg           <= NN'(1) << src_reg;
            round_reg         <= '0;
        end
        if (cmd.scan_clear)
        begin
            found_reg <= 1'b0;
            i_reg     <= '0;
        end
        if (cmd.scan_step)
        begin
            if (cand)
            begin
                found_reg     <= 1'b1;
                best_idx_reg  <= i_reg;
                best_dist_reg <= dist_reg[i_reg];
            end
            i_reg <= last_i ? '0 : i_reg + NB'(1);
        end
        if (cmd.pick)
        begin
            u_reg                 <= best_idx_reg;
            du_reg                <= best_dist_reg;
            vis_reg[best_idx_reg] <= 1'b1;
            que_reg[best_idx_reg] <= 1'b0;
            i_reg                 <= '0;
        end
        if (cmd.rd_issue)
        begin
            pres_q <= pres_reg[{u_reg, i_reg}];
        end
        if (cmd.relax)
        begin
            if (upd)
            begin
                dist_reg[i_reg] <= sum_sat;
                pred_reg[i_reg] <= u_reg;
                rch_reg[i_reg]  <= 1'b1;
                que_reg[i_reg]  <= 1'b1;
            end
            if (last_i)
            begin
                round_reg <= round_reg + CB'(1);
            end
            else
            begin
                i_reg <= i_reg + NB'(1);
            end
        end
        // The trace reads the destination's distance through the node counter.
        if (cmd.trace_start)
        begin
            hop_reg   <= dst_reg;
            steps_reg <= '0;
            i_reg     <= dst_reg;
        end
        if (cmd.trace_step)
        begin
            hop_reg   <= pred_reg[hop_reg];
            steps_reg <= steps_reg + CB'(1);
        end
        if (cmd.finish_zero)
        begin
            result_reg <= '0;
        end
        if (cmd.finish_self)
        begin
            result_reg.next_hop  <= src_reg;
            result_reg.path_cost <= '0;
            result_reg.reachable <= 1'b1;
        end
        if (cmd.finish_path)
        begin
            result_reg.next_hop  <= hop_reg;
            result_reg.path_cost <= dist_reg[i_reg];
            result_reg.reachable <= 1'b1;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

@@ design/spnh_chk.sv @@
// ----------------------------------------------------------------------------
// spnh_chk
// Port-level checks of the next hop engine, bound to the top level.
// ----------------------------------------------------------------------------
module spnh_chk (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input spnh_pkg::item_t   item,
    input logic              done,
    input spnh_pkg::result_t result,
    input logic              pready
);

    // A result word leaves the engine idle again.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("busy high with a result");

    // A query always occupies the engine.
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.kind == spnh_pkg::KIND_QUERY) |=> busy)
        else $error("query did not raise busy");

    // Results never come in consecutive cycles.
    a_done_gap: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("back to back results");

    // An unreachable result carries zero fields.
    a_unreach_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.reachable) |-> (result.next_hop == '0 && result.path_cost == '0))
        else $error("unreachable result with nonzero fields");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready) else $error("pready low");

endmodule

bind shortest_path_next_hop spnh_chk u_spnh_chk (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result),
    .pready (pready)
);
